### design/dlcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_pkg
// Shared types, codes and constants of the debug link command parser.
// ----------------------------------------------------------------------------
package dlcp_pkg;

  localparam int PARAM_COUNT = 10;
  localparam int FRAME_BYTES = 40;
  localparam int INDEX_BYTES = 2;
  localparam int WRITE_COUNT = (PARAM_COUNT < FRAME_BYTES / 4) ? PARAM_COUNT : FRAME_BYTES / 4;
  localparam int COUNT_W     = 6;
  localparam int SLOT_W      = 4;
  localparam int ADDR_W      = 6;

  // command bytes
  localparam logic [7:0] CMD_DUMP      = 8'h30;
  localparam logic [7:0] CMD_SEC_UP    = 8'h33;
  localparam logic [7:0] CMD_SEC_DOWN  = 8'h34;
  localparam logic [7:0] CMD_INDEX     = 8'h35;
  localparam logic [7:0] INDEX_COMMIT  = 8'h36;
  localparam logic [7:0] FRAME_LEAD    = 8'hAA;
  localparam logic [7:0] FRAME_OPEN    = 8'hAF;
  localparam logic [7:0] FRAME_TRAILER = 8'hAB;
  localparam logic [7:0] SAVE_LEAD     = 8'hAC;
  localparam logic [7:0] SAVE_CMD      = 8'hAD;

  // event kinds
  localparam logic [1:0] EV_WRITE  = 2'd0;
  localparam logic [1:0] EV_DUMP   = 2'd1;
  localparam logic [1:0] EV_SECTOR = 2'd2;
  localparam logic [1:0] EV_SAVE   = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_INDEX = 2'd2
  } mode_t;

  // microprogram steps; the trailer sequence relies on this order
  typedef enum logic [4:0] {
    ST_FETCH,
    ST_FRAME_WR,
    ST_INDEX_WR,
    ST_LEAVE,
    ST_FRAME_AB,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_SHIFT,
    ST_EMIT_WORD,
    ST_DUMP,
    ST_INDEX_LOAD,
    ST_SEC_INC,
    ST_SEC_DEC,
    ST_SEC_CLR,
    ST_ENTER_INDEX,
    ST_ENTER_FRAME,
    ST_SAVE
  } step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FRAME_WR,
    OP_INDEX_WR,
    OP_ENTER_FRAME,
    OP_ENTER_INDEX,
    OP_SEC_INC,
    OP_SEC_DEC,
    OP_SEC_CLR,
    OP_SEC_LOAD,
    OP_SLOT_CLR,
    OP_SLOT_INC
  } dp_op_t;

  typedef enum logic [1:0] {
    SQ_NEXT,
    SQ_GOTO,
    SQ_LOOP,
    SQ_DISPATCH
  } seq_t;

  typedef struct packed {
    seq_t       seq;
    step_t      target;
    dp_op_t     op;
    logic       leave;
    logic       emit;
    logic [1:0] kind;
    logic       last;
    logic       mem_rd;
    logic [1:0] lane;
    logic       shift;
  } ucode_t;

  typedef struct packed {
    dp_op_t     op;
    logic       leave;
    logic       emit;
    logic [1:0] kind;
    logic       last;
    logic       mem_rd;
    logic [1:0] lane;
    logic       shift;
    logic       fetch;
    logic       go;
  } ctrl_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] prev_byte;
    logic       frame_full;
    logic       index_full;
    logic       slot_last;
    logic       out_free;
    logic       accept;
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       storage_ready;
    logic       dump_pending;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [3:0]  param_slot;
    logic [31:0] param_word;
    logic [31:0] sector_number;
    logic        last_of_run;
  } evt_t;

endpackage

### design/dlcp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_sequencer
// Step counter, microcode table and command dispatch of the parser.
// ----------------------------------------------------------------------------
module dlcp_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  dlcp_pkg::cmd_t    cmd,
  input  dlcp_pkg::status_t status,
  output dlcp_pkg::ctrl_t   ctrl
);

  dlcp_pkg::step_t  pc;
  dlcp_pkg::step_t  pc_next;
  dlcp_pkg::ucode_t uc;
  logic             go;

  function automatic dlcp_pkg::ucode_t rom_word(input dlcp_pkg::step_t s);
    dlcp_pkg::ucode_t w;
    w        = '0;
    w.seq    = dlcp_pkg::SQ_GOTO;
    w.target = dlcp_pkg::ST_FETCH;
    w.op     = dlcp_pkg::OP_NONE;
    case (s)
      dlcp_pkg::ST_FETCH:       w.seq = dlcp_pkg::SQ_DISPATCH;
      dlcp_pkg::ST_FRAME_WR:    w.op = dlcp_pkg::OP_FRAME_WR;
      dlcp_pkg::ST_INDEX_WR:    w.op = dlcp_pkg::OP_INDEX_WR;
      dlcp_pkg::ST_LEAVE:       w.leave = 1'b1;
      dlcp_pkg::ST_FRAME_AB: begin
        w.op    = dlcp_pkg::OP_SLOT_CLR;
        w.leave = 1'b1;
        w.seq   = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_RD0: begin
        w.mem_rd = 1'b1;
        w.lane   = 2'd0;
        w.seq    = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_RD1: begin
        w.mem_rd = 1'b1;
        w.lane   = 2'd1;
        w.shift  = 1'b1;
        w.seq    = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_RD2: begin
        w.mem_rd = 1'b1;
        w.lane   = 2'd2;
        w.shift  = 1'b1;
        w.seq    = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_RD3: begin
        w.mem_rd = 1'b1;
        w.lane   = 2'd3;
        w.shift  = 1'b1;
        w.seq    = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_SHIFT: begin
        w.shift = 1'b1;
        w.seq   = dlcp_pkg::SQ_NEXT;
      end
      dlcp_pkg::ST_EMIT_WORD: begin
        w.emit   = 1'b1;
        w.kind   = dlcp_pkg::EV_WRITE;
        w.op     = dlcp_pkg::OP_SLOT_INC;
        w.seq    = dlcp_pkg::SQ_LOOP;
        w.target = dlcp_pkg::ST_RD0;
      end
      dlcp_pkg::ST_DUMP: begin
        w.emit = 1'b1;
        w.kind = dlcp_pkg::EV_DUMP;
        w.last = 1'b1;
      end
      dlcp_pkg::ST_INDEX_LOAD: begin
        w.op    = dlcp_pkg::OP_SEC_LOAD;
        w.leave = 1'b1;
        w.emit  = 1'b1;
        w.kind  = dlcp_pkg::EV_SECTOR;
        w.last  = 1'b1;
      end
      dlcp_pkg::ST_SEC_INC: begin
        w.op   = dlcp_pkg::OP_SEC_INC;
        w.emit = 1'b1;
        w.kind = dlcp_pkg::EV_SECTOR;
        w.last = 1'b1;
      end
      dlcp_pkg::ST_SEC_DEC: begin
        w.op   = dlcp_pkg::OP_SEC_DEC;
        w.emit = 1'b1;
        w.kind = dlcp_pkg::EV_SECTOR;
        w.last = 1'b1;
      end
      dlcp_pkg::ST_SEC_CLR: begin
        w.op   = dlcp_pkg::OP_SEC_CLR;
        w.emit = 1'b1;
        w.kind = dlcp_pkg::EV_SECTOR;
        w.last = 1'b1;
      end
      dlcp_pkg::ST_ENTER_INDEX: w.op = dlcp_pkg::OP_ENTER_INDEX;
      dlcp_pkg::ST_ENTER_FRAME: w.op = dlcp_pkg::OP_ENTER_FRAME;
      dlcp_pkg::ST_SAVE: begin
        w.emit = 1'b1;
        w.kind = dlcp_pkg::EV_SAVE;
        w.last = 1'b1;
      end
      default: w.seq = dlcp_pkg::SQ_GOTO;
    endcase
    return w;
  endfunction

  function automatic dlcp_pkg::step_t dispatch(input dlcp_pkg::cmd_t c,
                                               input dlcp_pkg::status_t st);
    dlcp_pkg::step_t t;
    t = dlcp_pkg::ST_FETCH;
    case (st.mode)
      dlcp_pkg::MODE_FRAME: begin
        if (!st.frame_full)
          t = dlcp_pkg::ST_FRAME_WR;
        else if (c.rx_byte == dlcp_pkg::FRAME_TRAILER)
          t = dlcp_pkg::ST_FRAME_AB;
        else
          t = dlcp_pkg::ST_LEAVE;
      end
      dlcp_pkg::MODE_INDEX: begin
        if (!st.index_full)
          t = dlcp_pkg::ST_INDEX_WR;
        else if (c.rx_byte == dlcp_pkg::INDEX_COMMIT)
          t = dlcp_pkg::ST_INDEX_LOAD;
        else
          t = dlcp_pkg::ST_LEAVE;
      end
      default: begin
        case (c.rx_byte)
          dlcp_pkg::CMD_DUMP:
            if (!c.dump_pending) t = dlcp_pkg::ST_DUMP;
          dlcp_pkg::CMD_SEC_UP:
            if (c.storage_ready) t = dlcp_pkg::ST_SEC_INC;
          dlcp_pkg::CMD_SEC_DOWN:
            if (c.storage_ready) t = dlcp_pkg::ST_SEC_DEC;
          dlcp_pkg::CMD_INDEX:
            if (c.storage_ready) t = dlcp_pkg::ST_ENTER_INDEX;
          dlcp_pkg::FRAME_OPEN:
            if (st.prev_byte == dlcp_pkg::FRAME_LEAD) t = dlcp_pkg::ST_ENTER_FRAME;
          dlcp_pkg::SAVE_CMD:
            if (st.prev_byte == dlcp_pkg::SAVE_LEAD) t = dlcp_pkg::ST_SAVE;
          default: t = dlcp_pkg::ST_SEC_CLR;
        endcase
      end
    endcase
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dlcp_pkg::ST_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uc = rom_word(pc);
    // hold a step that emits until the output register can take the result
    if (pc == dlcp_pkg::ST_FETCH)
      go = status.accept;
    else
      go = !uc.emit || status.out_free;

    ctrl.op     = uc.op;
    ctrl.leave  = uc.leave;
    ctrl.emit   = uc.emit;
    ctrl.kind   = uc.kind;
    ctrl.last   = uc.last;
    ctrl.mem_rd = uc.mem_rd;
    ctrl.lane   = uc.lane;
    ctrl.shift  = uc.shift;
    ctrl.fetch  = (pc == dlcp_pkg::ST_FETCH);
    ctrl.go     = go;

    pc_next = pc;
    if (go) begin
      case (uc.seq)
        dlcp_pkg::SQ_NEXT:     pc_next = dlcp_pkg::step_t'(pc + 5'd1);
        dlcp_pkg::SQ_GOTO:     pc_next = uc.target;
        dlcp_pkg::SQ_LOOP:
          pc_next = status.slot_last ? dlcp_pkg::step_t'(pc + 5'd1) : uc.target;
        dlcp_pkg::SQ_DISPATCH: pc_next = dispatch(cmd, status);
        default:               pc_next = dlcp_pkg::ST_FETCH;
      endcase
    end
  end

endmodule

### design/debug_link_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_link_command_parser_unit
// Turns received link bytes into parameter write, dump, sector and save
// events.
// ----------------------------------------------------------------------------
// One request on the cmd channel carries one received byte and two status
// flags. Each request yields zero or more events on the evt channel, the
// final one marked by last_of_run.
// A microcoded sequencer runs a short step program per byte: a byte that
// changes nothing goes straight back to fetch, any other byte except a good
// frame trailer runs the step for its command and returns to fetch. A frame
// trailer runs a step that leaves frame mode, then for each of the ten words
// four reads of the frame memory through its one registered read port, a
// step to shift in the last byte, then the emit; last comes the dump event.
// The next request is taken as soon as the last event sits in the output
// register. While evt_stall is high the output register holds its event and
// the program waits at its next emitting step; cmd_stall stays high until
// the program returns to fetch.
// Reset returns to idle decoding, clears the sector index and the previous
// byte, and drops evt_valid. Frame and index bytes are not cleared.
// ----------------------------------------------------------------------------
module debug_link_command_parser_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  dlcp_pkg::cmd_t cmd,
  output logic           evt_valid,
  input  logic           evt_stall,
  output dlcp_pkg::evt_t evt
);

  dlcp_pkg::ctrl_t   ctrl;
  dlcp_pkg::status_t status;

  dlcp_pkg::mode_t                mode;
  logic [dlcp_pkg::COUNT_W-1:0]   byte_count;
  logic [7:0]                     prev_byte;
  logic [7:0]                     cur_byte;
  logic [31:0]                    sector;
  logic [31:0]                    sector_next;
  logic [dlcp_pkg::SLOT_W-1:0]    slot;
  logic [31:0]                    word;
  logic [7:0]                     rd_data;
  logic [dlcp_pkg::ADDR_W-1:0]    rd_addr;
  logic [7:0]                     index_bytes [dlcp_pkg::INDEX_BYTES];
  logic [7:0]                     frame_mem   [dlcp_pkg::FRAME_BYTES];
  logic                           accept;
  logic                           out_free;

  assign cmd_stall = !ctrl.fetch;
  assign accept    = cmd_valid && ctrl.fetch;
  assign out_free  = !evt_valid || !evt_stall;
  assign rd_addr   = {slot, ctrl.lane};

  always_comb begin
    status.mode       = mode;
    status.prev_byte  = prev_byte;
    status.frame_full = byte_count >= dlcp_pkg::COUNT_W'(dlcp_pkg::FRAME_BYTES);
    status.index_full = byte_count >= dlcp_pkg::COUNT_W'(dlcp_pkg::INDEX_BYTES);
    status.slot_last  = slot == dlcp_pkg::SLOT_W'(dlcp_pkg::WRITE_COUNT - 1);
    status.out_free   = out_free;
    status.accept     = accept;
  end

  dlcp_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .ctrl   (ctrl)
  );

  always_comb begin
    case (ctrl.op)
      dlcp_pkg::OP_SEC_INC:  sector_next = sector + 32'd1;
      dlcp_pkg::OP_SEC_DEC:  sector_next = sector - 32'd1;
      dlcp_pkg::OP_SEC_CLR:  sector_next = '0;
      dlcp_pkg::OP_SEC_LOAD: sector_next = {sector[31:16], index_bytes[1], index_bytes[0]};
      default:               sector_next = sector;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= dlcp_pkg::MODE_IDLE;
      byte_count <= '0;
      prev_byte  <= '0;
      sector     <= '0;
      evt_valid  <= 1'b0;
    end else begin
      if (accept)
        prev_byte <= cmd.rx_byte;
      if (ctrl.go) begin
        sector <= sector_next;
        case (ctrl.op)
          dlcp_pkg::OP_FRAME_WR,
          dlcp_pkg::OP_INDEX_WR: byte_count <= byte_count + 1'b1;
          dlcp_pkg::OP_ENTER_FRAME: begin
            mode       <= dlcp_pkg::MODE_FRAME;
            byte_count <= '0;
          end
          dlcp_pkg::OP_ENTER_INDEX: begin
            mode       <= dlcp_pkg::MODE_INDEX;
            byte_count <= '0;
          end
          default: ;
        endcase
        if (ctrl.leave) begin
          mode       <= dlcp_pkg::MODE_IDLE;
          byte_count <= '0;
        end
      end
      if (ctrl.emit && ctrl.go)
        evt_valid <= 1'b1;
      else if (!evt_stall)
        evt_valid <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept)
      cur_byte <= cmd.rx_byte;
    if (ctrl.go && ctrl.op == dlcp_pkg::OP_INDEX_WR)
      index_bytes[byte_count[0]] <= cur_byte;
    if (ctrl.go && ctrl.op == dlcp_pkg::OP_SLOT_CLR)
      slot <= '0;
    else if (ctrl.go && ctrl.op == dlcp_pkg::OP_SLOT_INC)
      slot <= slot + 1'b1;
    // bytes arrive lowest first, shift in from the top
    if (ctrl.shift)
      word <= {rd_data, word[31:8]};
    if (ctrl.emit && ctrl.go) begin
      evt.event_kind    <= ctrl.kind;
      evt.param_slot    <= (ctrl.kind == dlcp_pkg::EV_WRITE) ? slot : '0;
      evt.param_word    <= (ctrl.kind == dlcp_pkg::EV_WRITE) ? word : '0;
      evt.sector_number <= (ctrl.kind == dlcp_pkg::EV_SECTOR) ? sector_next : '0;
      evt.last_of_run   <= ctrl.last;
    end
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.op == dlcp_pkg::OP_FRAME_WR)
      frame_mem[byte_count] <= cur_byte;
    if (ctrl.mem_rd)
      rd_data <= frame_mem[rd_addr];
  end

endmodule

### sim/debug_link_command_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_link_command_parser_unit_tb
// Self-checking testbench for the debug link command parser. Received bytes
// with random status flags go in through the cmd channel. A scoreboard
// decodes every accepted request on its own and checks each event on the
// evt channel, field by field, in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module debug_link_command_parser_unit_tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 500;
  localparam int DRAIN_WAIT  = 80;
  localparam int LONG_HOLD   = 500;
  localparam int HOLD_AT_EVT = 100;

  class event_scoreboard;
    dlcp_pkg::mode_t mode;
    logic [7:0]      prev_byte;
    logic [5:0]      count;
    logic [7:0]      frame_bytes[dlcp_pkg::FRAME_BYTES];
    logic [7:0]      index_bytes[dlcp_pkg::INDEX_BYTES];
    logic [31:0]     sector;
    dlcp_pkg::evt_t  awaited_events[$];
    int              errors;
    int              seen;

    function new();
      mode      = dlcp_pkg::MODE_IDLE;
      prev_byte = '0;
      count     = '0;
      sector    = '0;
      errors    = 0;
      seen      = 0;
    endfunction

    function dlcp_pkg::evt_t make_event(logic [1:0] kind, logic [3:0] slot,
                                        logic [31:0] word, logic [31:0] sec);
      dlcp_pkg::evt_t e;
      e.event_kind    = kind;
      e.param_slot    = slot;
      e.param_word    = word;
      e.sector_number = sec;
      e.last_of_run   = 1'b0;
      return e;
    endfunction

    // Decode one accepted request and queue the events it should cause.
    function void decode_request(dlcp_pkg::cmd_t c);
      dlcp_pkg::evt_t run[$];
      dlcp_pkg::evt_t e;
      logic [31:0]    word;
      int             a;
      case (mode)
        dlcp_pkg::MODE_FRAME: begin
          if (count < dlcp_pkg::FRAME_BYTES) begin
            frame_bytes[count] = c.rx_byte;
            count++;
          end else begin
            count = '0;
            mode  = dlcp_pkg::MODE_IDLE;
            if (c.rx_byte == dlcp_pkg::FRAME_TRAILER) begin
              for (int s = 0; s < dlcp_pkg::WRITE_COUNT; s++) begin
                a    = 4 * s;
                word = {frame_bytes[a + 3], frame_bytes[a + 2],
                        frame_bytes[a + 1], frame_bytes[a]};
                run.push_back(make_event(dlcp_pkg::EV_WRITE, 4'(s), word, '0));
              end
              run.push_back(make_event(dlcp_pkg::EV_DUMP, '0, '0, '0));
            end
          end
        end
        dlcp_pkg::MODE_INDEX: begin
          if (count >= dlcp_pkg::INDEX_BYTES) begin
            if (c.rx_byte == dlcp_pkg::INDEX_COMMIT) begin
              sector = {sector[31:16], index_bytes[1], index_bytes[0]};
              run.push_back(make_event(dlcp_pkg::EV_SECTOR, '0, '0, sector));
            end
            mode  = dlcp_pkg::MODE_IDLE;
            count = '0;
          end else begin
            index_bytes[count] = c.rx_byte;
            count++;
          end
        end
        default: begin
          case (c.rx_byte)
            dlcp_pkg::CMD_DUMP: begin
              if (!c.dump_pending)
                run.push_back(make_event(dlcp_pkg::EV_DUMP, '0, '0, '0));
            end
            dlcp_pkg::CMD_SEC_UP: begin
              if (c.storage_ready) begin
                sector = sector + 32'd1;
                run.push_back(make_event(dlcp_pkg::EV_SECTOR, '0, '0, sector));
              end
            end
            dlcp_pkg::CMD_SEC_DOWN: begin
              if (c.storage_ready) begin
                sector = sector - 32'd1;
                run.push_back(make_event(dlcp_pkg::EV_SECTOR, '0, '0, sector));
              end
            end
            dlcp_pkg::CMD_INDEX: begin
              if (c.storage_ready) begin
                mode  = dlcp_pkg::MODE_INDEX;
                count = '0;
              end
            end
            dlcp_pkg::FRAME_OPEN: begin
              if (prev_byte == dlcp_pkg::FRAME_LEAD) begin
                mode  = dlcp_pkg::MODE_FRAME;
                count = '0;
              end
            end
            dlcp_pkg::SAVE_CMD: begin
              if (prev_byte == dlcp_pkg::SAVE_LEAD)
                run.push_back(make_event(dlcp_pkg::EV_SAVE, '0, '0, '0));
            end
            default: begin
              mode   = dlcp_pkg::MODE_IDLE;
              sector = '0;
              run.push_back(make_event(dlcp_pkg::EV_SECTOR, '0, '0, sector));
            end
          endcase
        end
      endcase
      prev_byte = c.rx_byte;
      if (run.size() > 0) begin
        e = run.pop_back();
        e.last_of_run = 1'b1;
        run.push_back(e);
      end
      foreach (run[k]) awaited_events.push_back(run[k]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_event(dlcp_pkg::evt_t got);
      dlcp_pkg::evt_t want;
      seen++;
      if (awaited_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind %0d slot %0d word %h sector %h",
                 $time, got.event_kind, got.param_slot, got.param_word, got.sector_number);
        return;
      end
      want = awaited_events.pop_front();
      compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      compare_field("param_slot", 32'(want.param_slot), 32'(got.param_slot));
      compare_field("param_word", want.param_word, got.param_word);
      compare_field("sector_number", want.sector_number, got.sector_number);
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  dlcp_pkg::cmd_t cmd;
  logic           evt_valid;
  logic           evt_stall;
  dlcp_pkg::evt_t evt;

  event_scoreboard sb;
  bit              burst;
  int              items_sent;
  int              idle_cycles;

  debug_link_command_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic ready, input logic pend);
    dlcp_pkg::cmd_t c;
    int             gap;
    c.rx_byte       = b;
    c.storage_ready = ready;
    c.dump_pending  = pend;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    sb.decode_request(c);
    items_sent++;
  endtask

  task automatic send_any(input logic [7:0] b);
    send_byte(b, $urandom_range(0, 3) != 0, $urandom_range(0, 1) != 0);
  endtask

  // Lead, open, forty payload bytes, trailer.
  task automatic send_frame(input bit patterned, input bit good_trailer);
    logic [7:0] d;
    send_any(dlcp_pkg::FRAME_LEAD);
    send_any(dlcp_pkg::FRAME_OPEN);
    for (int k = 0; k < dlcp_pkg::FRAME_BYTES; k++) begin
      if (!patterned) d = 8'($urandom);
      else if (k == 0) d = 8'h00;
      else if (k == 1) d = 8'hFF;
      else d = 8'(k * 37 + 5);
      send_any(d);
    end
    send_any(good_trailer ? dlcp_pkg::FRAME_TRAILER : 8'($urandom));
  endtask

  task automatic send_index_load(input bit commit);
    send_byte(dlcp_pkg::CMD_INDEX, $urandom_range(0, 9) != 0, $urandom_range(0, 1) != 0);
    send_any(8'($urandom));
    send_any(8'($urandom));
    send_any(commit ? dlcp_pkg::INDEX_COMMIT : 8'($urandom));
  endtask

  task automatic send_command();
    case ($urandom_range(0, 8))
      0: send_any(dlcp_pkg::CMD_DUMP);
      1: send_any(dlcp_pkg::CMD_SEC_UP);
      2: send_any(dlcp_pkg::CMD_SEC_DOWN);
      3: begin
        send_any(dlcp_pkg::SAVE_LEAD);
        send_any(dlcp_pkg::SAVE_CMD);
      end
      4: send_any(dlcp_pkg::SAVE_CMD);
      5: send_any(dlcp_pkg::FRAME_OPEN);
      6: send_any(dlcp_pkg::FRAME_LEAD);
      7: send_any(dlcp_pkg::INDEX_COMMIT);
      default: send_any(dlcp_pkg::FRAME_TRAILER);
    endcase
  endtask

  // Receiver: stall a random number of cycles before each event, once for a
  // long stretch so the block backs up into the cmd channel.
  initial begin : receiver
    int  hold;
    bit  long_done;
    long_done = 0;
    evt_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!long_done && sb.seen == HOLD_AT_EVT) begin
        long_done = 1;
        hold = LONG_HOLD;
      end else begin
        hold = burst ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        evt_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        evt_stall <= 1'b0;
      end
      do @(posedge clk); while (!evt_valid);
      sb.check_event(evt);
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (cmd_valid && !cmd_stall) || (evt_valid && !evt_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seq_no;
    int r;
    sb         = new();
    burst      = 0;
    items_sent = 0;
    seq_no     = 0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: each command with both flag values, wrap, index loads, leads
    send_byte(dlcp_pkg::CMD_DUMP, 1'b1, 1'b0);
    send_byte(dlcp_pkg::CMD_DUMP, 1'b0, 1'b1);
    send_byte(dlcp_pkg::CMD_SEC_DOWN, 1'b1, 1'b0);
    send_byte(dlcp_pkg::CMD_SEC_UP, 1'b1, 1'b1);
    send_byte(dlcp_pkg::CMD_SEC_UP, 1'b0, 1'b0);
    send_byte(dlcp_pkg::CMD_SEC_DOWN, 1'b0, 1'b1);
    send_byte(dlcp_pkg::CMD_SEC_DOWN, 1'b1, 1'b0);
    send_byte(dlcp_pkg::CMD_INDEX, 1'b1, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(dlcp_pkg::CMD_SEC_DOWN, 1'b0, 1'b1);
    send_byte(dlcp_pkg::INDEX_COMMIT, 1'b0, 1'b1);
    send_byte(dlcp_pkg::CMD_INDEX, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(dlcp_pkg::CMD_INDEX, 1'b0, 1'b0);
    send_byte(dlcp_pkg::FRAME_OPEN, 1'b1, 1'b0);
    send_byte(dlcp_pkg::SAVE_LEAD, 1'b0, 1'b1);
    send_byte(dlcp_pkg::SAVE_CMD, 1'b1, 1'b1);
    send_byte(dlcp_pkg::SAVE_CMD, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_frame(1'b1, 1'b1);

    // random: mostly well-formed sequences, some broken ones and noise
    while (items_sent < RAND_ITEMS) begin
      seq_no++;
      burst = (seq_no % 10) >= 7;
      r = $urandom_range(0, 99);
      if (r < 12) send_frame(1'b0, $urandom_range(0, 4) != 0);
      else if (r < 30) send_index_load($urandom_range(0, 4) != 0);
      else if (r < 70) send_command();
      else send_any(8'($urandom));
    end
    burst = 0;
    cmd_valid <= 1'b0;

    while (sb.awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
